[design/pflc_pkg.sv]
package pflc_pkg;

    // defaults for the top level parameters
    localparam int DEF_NUM_FRAMES    = 4;
    localparam int DEF_PAGE_ELEMENTS = 128;   // power of two
    localparam int DEF_INDEX_BITS    = 24;

    // width of the hit and fault totals
    localparam int CNT_W = 32;

endpackage

[design/pflc_in_if.sv]
interface pflc_in_if #(
    parameter int INDEX_W = 24
);
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] element_index;

    modport source (output valid, output element_index, input ready);
    modport sink   (input valid, input element_index, output ready);
endinterface

[design/pflc_out_if.sv]
interface pflc_out_if
    import pflc_pkg::*;
#(
    parameter int FRAME_W  = 2,
    parameter int OFFSET_W = 7,
    parameter int PAGE_W   = 17
);
    logic                valid;
    logic                ready;
    logic                out_of_bounds;
    logic                hit;
    logic [FRAME_W-1:0]  frame;
    logic [OFFSET_W-1:0] offset;
    logic                load_needed;
    logic [PAGE_W-1:0]   load_page;
    logic                write_back;
    logic [PAGE_W-1:0]   evicted_page;
    logic [CNT_W-1:0]    hit_count;
    logic [CNT_W-1:0]    fault_count;

    modport source (
        output valid, output out_of_bounds, output hit, output frame, output offset,
        output load_needed, output load_page, output write_back, output evicted_page,
        output hit_count, output fault_count,
        input  ready
    );
    modport sink (
        input  valid, input out_of_bounds, input hit, input frame, input offset,
        input  load_needed, input load_page, input write_back, input evicted_page,
        input  hit_count, input fault_count,
        output ready
    );
endinterface

[design/pflc_cell.sv]
module pflc_cell #(
    parameter int NUM_FRAMES = 4,
    parameter int PAGE_W     = 17,
    parameter int CELL_IDX   = 0,
    localparam int FRAME_W   = $clog2(NUM_FRAMES)
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [3*FRAME_W+PAGE_W+1:0] i_upd,
    input  logic [7*FRAME_W+2*PAGE_W+2:0] i_sweep,
    output logic [7*FRAME_W+2*PAGE_W+2:0] o_sweep
);
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [FRAME_W-1:0] hit_frame;
        logic [FRAME_W-1:0] hit_rank;
        logic               empty;
        logic [FRAME_W-1:0] empty_frame;
        logic [FRAME_W-1:0] empty_rank;
        logic [FRAME_W-1:0] lru_frame;
        logic [FRAME_W-1:0] lru_rank;
        logic [PAGE_W-1:0]  lru_tag;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] spare;
    } t_sweep;

    typedef struct packed {
        logic               en;
        logic               fill;
        logic [FRAME_W-1:0] frame;
        logic [FRAME_W-1:0] rank;
        logic [FRAME_W-1:0] spare;
        logic [PAGE_W-1:0]  page;
    } t_upd;

    localparam logic [FRAME_W-1:0] MY_FRAME = FRAME_W'(CELL_IDX);
    localparam logic [FRAME_W-1:0] LRU_RANK = FRAME_W'(NUM_FRAMES - 1);

    t_sweep w_in, n_out, r_out;
    t_upd   w_upd;

    logic [PAGE_W-1:0]  r_tag;
    logic               r_valid;
    logic [FRAME_W-1:0] r_rank;

    assign w_in    = t_sweep'(i_sweep);
    assign w_upd   = t_upd'(i_upd);
    assign o_sweep = r_out;

    // merge this frame into the beat coming from the left
    always_comb begin
        n_out = w_in;
        if (!w_in.hit && r_valid && (r_tag == w_in.page)) begin
            n_out.hit       = 1'b1;
            n_out.hit_frame = MY_FRAME;
            n_out.hit_rank  = r_rank;
        end
        if (!w_in.empty && !r_valid) begin
            n_out.empty       = 1'b1;
            n_out.empty_frame = MY_FRAME;
            n_out.empty_rank  = r_rank;
        end
        if (r_rank == LRU_RANK) begin
            n_out.lru_frame = MY_FRAME;
            n_out.lru_rank  = r_rank;
            n_out.lru_tag   = r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
            r_valid     <= 1'b0;
            r_rank      <= MY_FRAME;
        end else begin
            r_out.valid <= w_in.valid;
            if (w_upd.en) begin
                if (w_upd.frame == MY_FRAME) begin
                    r_rank <= '0;
                    if (w_upd.fill) begin
                        r_valid <= 1'b1;
                    end
                end else if (r_rank < w_upd.rank) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
        end
        // payload, no reset needed
        if (w_in.valid) begin
            r_out.hit         <= n_out.hit;
            r_out.hit_frame   <= n_out.hit_frame;
            r_out.hit_rank    <= n_out.hit_rank;
            r_out.empty       <= n_out.empty;
            r_out.empty_frame <= n_out.empty_frame;
            r_out.empty_rank  <= n_out.empty_rank;
            r_out.lru_frame   <= n_out.lru_frame;
            r_out.lru_rank    <= n_out.lru_rank;
            r_out.lru_tag     <= n_out.lru_tag;
            r_out.page        <= n_out.page;
            r_out.spare       <= n_out.spare;
        end
        if (w_upd.en && w_upd.fill && (w_upd.frame == MY_FRAME)) begin
            r_tag <= w_upd.page;
        end
    end

endmodule

[design/page_frame_lru_cache.sv]
// path: an out-of-bounds beat goes from acceptance to S_RESULT and then to the
// output register; an in-bounds beat first ripples its lookup beat down the
// chain, one frame cell per cycle, in S_SCAN, before S_RESULT
// flow: a new beat is taken only in S_IDLE, once the last result is registered;
// a stall at the output holds the block in S_RESULT
// reset: synchronous active-low; frames empty, ranks equal frame numbers,
// totals and element count zero, so all accesses are out of bounds until written
module page_frame_lru_cache
    import pflc_pkg::*;
#(
    parameter int NUM_FRAMES    = DEF_NUM_FRAMES,
    parameter int PAGE_ELEMENTS = DEF_PAGE_ELEMENTS,
    parameter int INDEX_BITS    = DEF_INDEX_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [INDEX_BITS:0] i_cfg_data,
    pflc_in_if.sink             i_in,
    pflc_out_if.source          o_out
);
    localparam int FRAME_W  = $clog2(NUM_FRAMES);
    localparam int OFFSET_W = $clog2(PAGE_ELEMENTS);
    localparam int PAGE_W   = INDEX_BITS - OFFSET_W;
    localparam int SWEEP_W  = 7*FRAME_W + 2*PAGE_W + 3;
    localparam logic [FRAME_W-1:0] LRU_RANK = FRAME_W'(NUM_FRAMES - 1);
    localparam logic [CNT_W-1:0]   CNT_MAX  = '1;

    // lookup beat that travels down the cell chain
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [FRAME_W-1:0] hit_frame;
        logic [FRAME_W-1:0] hit_rank;
        logic               empty;
        logic [FRAME_W-1:0] empty_frame;
        logic [FRAME_W-1:0] empty_rank;
        logic [FRAME_W-1:0] lru_frame;
        logic [FRAME_W-1:0] lru_rank;
        logic [PAGE_W-1:0]  lru_tag;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] spare;
    } t_sweep;

    // state update broadcast to every cell at the end of an in-bounds access
    typedef struct packed {
        logic               en;
        logic               fill;
        logic [FRAME_W-1:0] frame;
        logic [FRAME_W-1:0] rank;
        logic [FRAME_W-1:0] spare;
        logic [PAGE_W-1:0]  page;
    } t_upd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } t_state;

    t_state r_state;

    logic [INDEX_BITS:0]  r_count;
    logic                 r_oob;
    logic [OFFSET_W-1:0]  r_offset;
    logic [CNT_W-1:0]     r_hits;
    logic [CNT_W-1:0]     r_faults;

    // output register
    logic                 r_o_valid;
    logic                 r_o_oob;
    logic                 r_o_hit;
    logic [FRAME_W-1:0]   r_o_frame;
    logic [OFFSET_W-1:0]  r_o_offset;
    logic                 r_o_load;
    logic [PAGE_W-1:0]    r_o_load_page;
    logic                 r_o_wb;
    logic [PAGE_W-1:0]    r_o_evicted;

    logic [SWEEP_W-1:0]   w_chain [NUM_FRAMES+1];
    t_sweep               w_head;
    t_sweep               w_tail;
    t_upd                 w_upd;

    logic                 w_accept;
    logic                 w_in_oob;
    logic                 w_out_free;
    logic                 w_finish;

    // result selection for an in-bounds access
    logic                 n_hit;
    logic [FRAME_W-1:0]   n_frame;
    logic [FRAME_W-1:0]   n_rank;
    logic                 n_wb;
    logic [CNT_W-1:0]     n_hits;
    logic [CNT_W-1:0]     n_faults;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in_oob   = ({1'b0, i_in.element_index} >= r_count);
    assign w_out_free = !r_o_valid || o_out.ready;
    assign w_finish   = (r_state == S_RESULT) && w_out_free;

    // inject the lookup beat into the head of the chain on acceptance of an in-bounds access
    always_comb begin
        w_head       = '0;
        w_head.valid = w_accept && !w_in_oob;
        w_head.page  = i_in.element_index[INDEX_BITS-1:OFFSET_W];
    end

    assign w_chain[0] = w_head;
    assign w_tail     = t_sweep'(w_chain[NUM_FRAMES]);

    // one cell per frame: tag, valid bit and recency rank
    for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
        pflc_cell #(
            .NUM_FRAMES (NUM_FRAMES),
            .PAGE_W     (PAGE_W),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_upd   (w_upd),
            .i_sweep (w_chain[g]),
            .o_sweep (w_chain[g+1])
        );
    end

    // hit wins, then the lowest empty frame, else evict the lru frame; also the saturating totals
    always_comb begin
        n_hit = w_tail.hit;
        n_wb  = 1'b0;
        priority if (w_tail.hit) begin
            n_frame = w_tail.hit_frame;
            n_rank  = w_tail.hit_rank;
        end else if (w_tail.empty) begin
            n_frame = w_tail.empty_frame;
            n_rank  = w_tail.empty_rank;
        end else begin
            n_frame = w_tail.lru_frame;
            n_rank  = LRU_RANK;
            n_wb    = 1'b1;
        end
        n_hits   = r_hits;
        n_faults = r_faults;
        if (!r_oob) begin
            if (n_hit) begin
                n_hits = (r_hits == CNT_MAX) ? r_hits : r_hits + 1'b1;
            end else begin
                n_faults = (r_faults == CNT_MAX) ? r_faults : r_faults + 1'b1;
            end
        end
    end

    // every in-bounds access makes its frame most recent; a fault also fills it
    always_comb begin
        w_upd       = '0;
        w_upd.en    = w_finish && !r_oob;
        w_upd.fill  = !n_hit;
        w_upd.frame = n_frame;
        w_upd.rank  = n_rank;
        w_upd.page  = w_tail.page;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_hits    <= '0;
            r_faults  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            // a new result replaces the one leaving in the same cycle
            if (w_finish) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= w_in_oob ? S_RESULT : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_tail.valid) begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_state   <= S_IDLE;
                        r_hits    <= n_hits;
                        r_faults  <= n_faults;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        // payload, no reset needed
        if (w_accept) begin
            r_oob    <= w_in_oob;
            r_offset <= i_in.element_index[OFFSET_W-1:0];
        end
        if (w_finish) begin
            r_o_oob       <= r_oob;
            r_o_hit       <= !r_oob && n_hit;
            r_o_frame     <= r_oob ? '0 : n_frame;
            r_o_offset    <= r_oob ? '0 : r_offset;
            r_o_load      <= !r_oob && !n_hit;
            r_o_load_page <= (!r_oob && !n_hit) ? w_tail.page : '0;
            r_o_wb        <= !r_oob && !n_hit && n_wb;
            r_o_evicted   <= (!r_oob && !n_hit && n_wb) ? w_tail.lru_tag : '0;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.out_of_bounds = r_o_oob;
    assign o_out.hit           = r_o_hit;
    assign o_out.frame         = r_o_frame;
    assign o_out.offset        = r_o_offset;
    assign o_out.load_needed   = r_o_load;
    assign o_out.load_page     = r_o_load_page;
    assign o_out.write_back    = r_o_wb;
    assign o_out.evicted_page  = r_o_evicted;
    assign o_out.hit_count     = r_hits;
    assign o_out.fault_count   = r_faults;

endmodule
